[sv/binary_image_dfs_direction_trace_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the binary image direction tracer
// Immediate-consequence and next-cycle implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_DFS_DIRECTION_TRACE_ASSERT_SVH
`define BINARY_IMAGE_DFS_DIRECTION_TRACE_ASSERT_SVH

`ifndef SYNTHESIS
`define BIDT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bidt: implication check failed");
`define BIDT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bidt: next-cycle check failed");
`else
`define BIDT_ASSERT_IMP(label, ante, cons)
`define BIDT_ASSERT_NXT(label, ante, cons)
`endif

`endif

[sv/bidt_pkg.sv]
// ----------------------------------------------------------------------------
// bidt_pkg
// Shared types, codes and microcode for the binary image direction tracer.
// ----------------------------------------------------------------------------
package bidt_pkg;

   localparam int MAX_ROWS_DEF = 8;
   localparam int MAX_COLS_DEF = 8;

   localparam int OP_W       = 3;
   localparam int COORD_W    = 3;
   localparam int DIR_W      = 2;
   localparam int NDIR_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam int FRAME_W    = 2 * COORD_W + NDIR_W + 1;
   localparam int PC_W       = 4;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE         = 3'd0,
      OP_INVERT        = 3'd1,
      OP_CLEAR_GRID    = 3'd2,
      OP_CLEAR_VISITED = 3'd3,
      OP_TRACE         = 3'd4
   } op_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_ROWS = 1'b0,
      REG_IMAGE_COLS = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      C_NEVER        = 4'd0,
      C_ALWAYS       = 4'd1,
      C_NO_REQ       = 4'd2,
      C_NOT_TRACE    = 4'd3,
      C_BAD_START    = 4'd4,
      C_TOP_DONE     = 4'd5,
      C_NB_BAD       = 4'd6,
      C_NO_EMIT      = 4'd7,
      C_EMIT_BLOCKED = 4'd8,
      C_DEPTH_ONE    = 4'd9,
      C_OUT_BUSY     = 4'd10
   } cond_type;

   typedef struct packed {
      logic no_req;
      logic not_trace;
      logic bad_start;
      logic top_done;
      logic nb_bad;
      logic no_emit;
      logic emit_blocked;
      logic depth_one;
      logic out_busy;
   } cond_flags_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic init;
      logic start;
      logic trial;
      logic record;
      logic push;
      logic pop;
      logic load;
      logic wrap;
   } act_type;

   typedef struct packed {
      cond_type        cond;
      logic [PC_W-1:0] target;
      act_type         act;
   } ucode_type;

   localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] PC_EXEC  = 4'd1;
   localparam logic [PC_W-1:0] PC_CHECK = 4'd2;
   localparam logic [PC_W-1:0] PC_START = 4'd3;
   localparam logic [PC_W-1:0] PC_LOOP  = 4'd4;
   localparam logic [PC_W-1:0] PC_TRIAL = 4'd5;
   localparam logic [PC_W-1:0] PC_TEST  = 4'd6;
   localparam logic [PC_W-1:0] PC_DECIDE = 4'd7;
   localparam logic [PC_W-1:0] PC_EMIT  = 4'd8;
   localparam logic [PC_W-1:0] PC_PUSH  = 4'd9;
   localparam logic [PC_W-1:0] PC_POP   = 4'd10;
   localparam logic [PC_W-1:0] PC_RELOAD = 4'd11;
   localparam logic [PC_W-1:0] PC_FIN   = 4'd15;

   // Program: a fall-through from the final step wraps back to idle.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{cond: C_NEVER, target: PC_IDLE, act: '0};
      unique case (pc)
         PC_IDLE: begin
            w.cond = C_NO_REQ;  w.target = PC_IDLE;  w.act.accept = 1'b1;
         end
         PC_EXEC: begin
            w.cond = C_NOT_TRACE;  w.target = PC_FIN;
            w.act.exec = 1'b1;  w.act.init = 1'b1;
         end
         PC_CHECK: begin
            w.cond = C_BAD_START;  w.target = PC_FIN;
         end
         PC_START: begin
            w.act.start = 1'b1;
         end
         PC_LOOP: begin
            w.cond = C_TOP_DONE;  w.target = PC_POP;
         end
         PC_TRIAL: begin
            w.act.trial = 1'b1;
         end
         PC_TEST: begin
            w.cond = C_NB_BAD;  w.target = PC_LOOP;
         end
         PC_DECIDE: begin
            w.cond = C_NO_EMIT;  w.target = PC_PUSH;
         end
         PC_EMIT: begin
            w.cond = C_EMIT_BLOCKED;  w.target = PC_EMIT;  w.act.record = 1'b1;
         end
         PC_PUSH: begin
            w.cond = C_ALWAYS;  w.target = PC_LOOP;  w.act.push = 1'b1;
         end
         PC_POP: begin
            w.cond = C_DEPTH_ONE;  w.target = PC_FIN;  w.act.pop = 1'b1;
         end
         PC_RELOAD: begin
            w.cond = C_ALWAYS;  w.target = PC_LOOP;  w.act.load = 1'b1;
         end
         PC_FIN: begin
            w.cond = C_OUT_BUSY;  w.target = PC_FIN;  w.act.wrap = 1'b1;
         end
         default: begin
            w.cond = C_ALWAYS;  w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/bidt_ram.sv]
// ----------------------------------------------------------------------------
// bidt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bidt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bidt_seq.sv]
// ----------------------------------------------------------------------------
// bidt_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module bidt_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  bidt_pkg::cond_flags_type flags,
   output bidt_pkg::ucode_type      ucode
);

   import bidt_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            jump;

   assign ucode = ucode_rom(pc_ff);

   always_comb begin
      unique case (ucode.cond)
         C_NEVER:        jump = 1'b0;
         C_ALWAYS:       jump = 1'b1;
         C_NO_REQ:       jump = flags.no_req;
         C_NOT_TRACE:    jump = flags.not_trace;
         C_BAD_START:    jump = flags.bad_start;
         C_TOP_DONE:     jump = flags.top_done;
         C_NB_BAD:       jump = flags.nb_bad;
         C_NO_EMIT:      jump = flags.no_emit;
         C_EMIT_BLOCKED: jump = flags.emit_blocked;
         C_DEPTH_ONE:    jump = flags.depth_one;
         C_OUT_BUSY:     jump = flags.out_busy;
         default:        jump = 1'b1;
      endcase
      pc_in = jump ? ucode.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[sv/binary_image_dfs_direction_trace.sv]
// ----------------------------------------------------------------------------
// binary_image_dfs_direction_trace
// Binary pixel grid with a visited map and a depth-first direction tracer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per operation: write pixel, invert pixel,
//   clear grid, clear visited map or trace from (req_row, req_col).
//   rsp_* returns one or more transactions per request; rsp_last marks the
//   final one. A trace returns one transaction per recorded step; every
//   other request, and a trace without steps, returns one empty transaction.
//   csr_* writes image_rows (index 0) and image_cols (index 1) while idle.
// Timing:
//   One request at a time; req_stall is low only while the sequencer waits
//   for work. A non-trace request is accepted in the idle step, executed in
//   the exec step and answered from the final step. A trace tries each
//   direction in turn through the single neighbour lookup, pushes a frame to
//   the stack RAM for each pixel reached and reloads a frame on each pixel
//   left but the start pixel, all in one microcode loop.
// Reset and stall:
//   Reset clears grid, visited map and counters and sets both sizes to 8.
//   A response is held in an output register; while rsp_stall is high the
//   trace halts at its next result until the held one is taken.
// ----------------------------------------------------------------------------
module binary_image_dfs_direction_trace #(
   parameter int MAX_ROWS = bidt_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = bidt_pkg::MAX_COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bidt_pkg::OP_W-1:0]       req_op,
   input  logic [bidt_pkg::COORD_W-1:0]    req_row,
   input  logic [bidt_pkg::COORD_W-1:0]    req_col,
   input  logic                            req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bidt_pkg::DIR_W-1:0]      rsp_direction,
   output logic                            rsp_has_direction,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [bidt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bidt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import bidt_pkg::*;

`include "binary_image_dfs_direction_trace_assert.svh"

   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int DEPTH_W = $clog2(CELLS + 1);
   localparam int ADDR_W  = $clog2(CELLS);

   function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
      cell_of = CELL_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   logic [CSR_DATA_W-1:0] rows_ff, cols_ff, rows_in, cols_in;
   logic [CSR_DATA_W-1:0] rows_used, cols_used;

   op_type               op_ff, op_in;
   logic [COORD_W-1:0]   row_ff, col_ff, row_in, col_in;
   logic                 val_ff, val_in;

   logic [CELLS-1:0]     pixel_ff, pixel_in;
   logic [CELLS-1:0]     visited_ff, visited_in;

   logic [COORD_W-1:0]   cur_r_ff, cur_c_ff, cur_r_in, cur_c_in;
   logic [NDIR_W-1:0]    cur_dir_ff, cur_dir_in;
   logic                 cur_moved_ff, cur_moved_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;

   logic                 nb_ok_ff, nb_ok_in;
   logic [COORD_W-1:0]   nb_r_ff, nb_c_ff, nb_r_in, nb_c_in;
   dir_type              step_dir_ff, step_dir_in;

   dir_type              last_dir_ff, last_dir_in;
   logic                 emitted_ff, emitted_in;
   logic                 pend_valid_ff, pend_valid_in;
   dir_type              pend_dir_ff, pend_dir_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]     rsp_dir_ff, rsp_dir_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_last_ff, rsp_last_in;

   ucode_type            ucode;
   cond_flags_type       flags;

   logic                 fire, out_free, out_load, record_go, need_emit, start_ok;
   logic                 pix_ok, edge_ok, nb_ok;
   logic [CELL_W-1:0]    pix_cell, nb_cell;
   logic [COORD_W-1:0]   nr, nc;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [FRAME_W-1:0]   ram_wdata, ram_rdata;

   bidt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ucode (ucode)
   );

   bidt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (CELLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rows_used = (rows_ff > CSR_DATA_W'(MAX_ROWS)) ? CSR_DATA_W'(MAX_ROWS) : rows_ff;
   assign cols_used = (cols_ff > CSR_DATA_W'(MAX_COLS)) ? CSR_DATA_W'(MAX_COLS) : cols_ff;

   assign pix_cell = cell_of(row_ff, col_ff);
   assign pix_ok   = ({1'b0, row_ff} < rows_used) && ({1'b0, col_ff} < cols_used);
   assign start_ok = pix_ok;

   // neighbour in the direction about to be tried
   always_comb begin
      nr = cur_r_ff;
      nc = cur_c_ff;
      unique case (dir_type'(cur_dir_ff[DIR_W-1:0]))
         DIR_UP: begin
            edge_ok = cur_r_ff != '0;
            nr      = cur_r_ff - 1'b1;
         end
         DIR_RIGHT: begin
            edge_ok = ({1'b0, cur_c_ff} + CSR_DATA_W'(1)) < cols_used;
            nc      = cur_c_ff + 1'b1;
         end
         DIR_DOWN: begin
            edge_ok = ({1'b0, cur_r_ff} + CSR_DATA_W'(1)) < rows_used;
            nr      = cur_r_ff + 1'b1;
         end
         DIR_LEFT: begin
            edge_ok = cur_c_ff != '0;
            nc      = cur_c_ff - 1'b1;
         end
         default: edge_ok = 1'b0;
      endcase
   end

   assign nb_cell = cell_of(nr, nc);
   assign nb_ok   = edge_ok && pixel_ff[nb_cell] && !visited_ff[nb_cell];

   assign fire      = req_valid && ucode.act.accept;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign record_go = ucode.act.record && !(pend_valid_ff && !out_free);
   assign out_load  = (ucode.act.record && pend_valid_ff && out_free)
                      || (ucode.act.wrap && out_free);
   assign need_emit = cur_moved_ff || !emitted_ff || (last_dir_ff != step_dir_ff);

   always_comb begin
      flags.no_req       = !req_valid;
      flags.not_trace    = op_ff != OP_TRACE;
      flags.bad_start    = !start_ok;
      flags.top_done     = cur_dir_ff[NDIR_W-1];
      flags.nb_bad       = !nb_ok_ff;
      flags.no_emit      = !need_emit;
      flags.emit_blocked = pend_valid_ff && !out_free;
      flags.depth_one    = depth_ff == DEPTH_W'(1);
      flags.out_busy     = !out_free;
   end

   assign ram_we    = ucode.act.push;
   assign ram_waddr = ADDR_W'(depth_ff - DEPTH_W'(1));
   assign ram_wdata = {cur_r_ff, cur_c_ff, cur_dir_ff, 1'b1};
   assign ram_raddr = ADDR_W'(depth_ff - DEPTH_W'(2));

   always_comb begin
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      pixel_in      = pixel_ff;
      visited_in    = visited_ff;
      cur_r_in      = cur_r_ff;
      cur_c_in      = cur_c_ff;
      cur_dir_in    = cur_dir_ff;
      cur_moved_in  = cur_moved_ff;
      depth_in      = depth_ff;
      nb_ok_in      = nb_ok_ff;
      nb_r_in       = nb_r_ff;
      nb_c_in       = nb_c_ff;
      step_dir_in   = step_dir_ff;
      last_dir_in   = last_dir_ff;
      emitted_in    = emitted_ff;
      pend_valid_in = pend_valid_ff;
      pend_dir_in   = pend_dir_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_dir_in    = rsp_dir_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_IMAGE_ROWS: rows_in = csr_wdata;
            REG_IMAGE_COLS: cols_in = csr_wdata;
            default: ;
         endcase
      end

      if (fire) begin
         op_in  = op_type'(req_op);
         row_in = req_row;
         col_in = req_col;
         val_in = req_pixel_value;
      end

      if (ucode.act.exec) begin
         unique case (op_ff)
            OP_WRITE:         if (pix_ok) pixel_in[pix_cell] = val_ff;
            OP_INVERT:        if (pix_ok) pixel_in[pix_cell] = !pixel_ff[pix_cell];
            OP_CLEAR_GRID:    pixel_in = '0;
            OP_CLEAR_VISITED: visited_in = '0;
            default: ;
         endcase
      end

      if (ucode.act.init) begin
         emitted_in    = 1'b0;
         last_dir_in   = DIR_UP;
         pend_valid_in = 1'b0;
      end

      if (ucode.act.start) begin
         visited_in[pix_cell] = 1'b1;
         cur_r_in     = row_ff;
         cur_c_in     = col_ff;
         cur_dir_in   = '0;
         cur_moved_in = 1'b0;
         depth_in     = DEPTH_W'(1);
      end

      if (ucode.act.trial) begin
         nb_ok_in    = nb_ok;
         nb_r_in     = nr;
         nb_c_in     = nc;
         step_dir_in = dir_type'(cur_dir_ff[DIR_W-1:0]);
         cur_dir_in  = cur_dir_ff + 1'b1;
      end

      if (record_go) begin
         pend_dir_in   = step_dir_ff;
         pend_valid_in = 1'b1;
         last_dir_in   = step_dir_ff;
         emitted_in    = 1'b1;
      end

      if (ucode.act.push) begin
         visited_in[cell_of(nb_r_ff, nb_c_ff)] = 1'b1;
         cur_r_in     = nb_r_ff;
         cur_c_in     = nb_c_ff;
         cur_dir_in   = '0;
         cur_moved_in = 1'b0;
         depth_in     = depth_ff + 1'b1;
      end

      if (ucode.act.pop) begin
         depth_in = depth_ff - 1'b1;
      end

      if (ucode.act.load) begin
         {cur_r_in, cur_c_in, cur_dir_in, cur_moved_in} = ram_rdata;
      end

      if (ucode.act.wrap && out_free) begin
         pend_valid_in = 1'b0;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_dir_in   = pend_valid_ff ? pend_dir_ff : DIR_UP;
         rsp_has_in   = pend_valid_ff;
         rsp_last_in  = ucode.act.wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= CSR_DATA_W'(8);
         cols_ff       <= CSR_DATA_W'(8);
         pixel_ff      <= '0;
         visited_ff    <= '0;
         depth_ff      <= '0;
         last_dir_ff   <= DIR_UP;
         emitted_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         pixel_ff      <= pixel_in;
         visited_ff    <= visited_in;
         depth_ff      <= depth_in;
         last_dir_ff   <= last_dir_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      val_ff       <= val_in;
      cur_r_ff     <= cur_r_in;
      cur_c_ff     <= cur_c_in;
      cur_dir_ff   <= cur_dir_in;
      cur_moved_ff <= cur_moved_in;
      nb_ok_ff     <= nb_ok_in;
      nb_r_ff      <= nb_r_in;
      nb_c_ff      <= nb_c_in;
      step_dir_ff  <= step_dir_in;
      pend_dir_ff  <= pend_dir_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall         = !ucode.act.accept;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction     = rsp_dir_ff;
   assign rsp_has_direction = rsp_has_ff;
   assign rsp_last          = rsp_last_ff;

   `BIDT_ASSERT_IMP(a_depth_bound, 1'b1, depth_ff <= DEPTH_W'(CELLS))
   `BIDT_ASSERT_IMP(a_accept_clean, req_valid && !req_stall, depth_ff == '0 && !pend_valid_ff)
   `BIDT_ASSERT_IMP(a_push_legal, ucode.act.push, nb_ok_ff && depth_ff != '0)
   `BIDT_ASSERT_IMP(a_load_free, out_load, out_free)
   `BIDT_ASSERT_NXT(a_start_marks, ucode.act.start, visited_ff[pix_cell] && depth_ff == DEPTH_W'(1))

endmodule

[tb/binary_image_dfs_direction_trace_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_image_dfs_direction_trace_tb
// Self-checking bench for the pixel grid depth-first direction tracer.
// A behavioural copy of the grid, visited map and walk stack predicts every
// response transaction. Directed requests cover the operation codes and the
// corner cases. Size register sweeps, a full-grid walk after a long output
// hold-off and random-walk shapes with random start points follow. The
// sender idles in bursts and the receiver stalls in several patterns.
// ----------------------------------------------------------------------------
module binary_image_dfs_direction_trace_tb;
   import bidt_pkg::*;

   localparam int GRID_ROWS       = MAX_ROWS_DEF;
   localparam int GRID_COLS       = MAX_COLS_DEF;
   localparam int GRID_CELLS      = GRID_ROWS * GRID_COLS;
   localparam int STACK_ENTRIES   = 64;
   localparam int DIR_COUNT       = 4;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 120;
   localparam int DRAIN_LIMIT     = 200000;
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [OP_W-1:0] OP_LAST_CODE    = 3'd7;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   typedef struct packed {
      dir_type direction;
      logic    has_direction;
      logic    last;
   } step_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op;
   logic [COORD_W-1:0]    req_row;
   logic [COORD_W-1:0]    req_col;
   logic                  req_pixel_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DIR_W-1:0]      rsp_direction;
   logic                  rsp_has_direction;
   logic                  rsp_last;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic [GRID_CELLS-1:0] pixel_model;
   logic [GRID_CELLS-1:0] visited_model;
   logic [CSR_DATA_W-1:0] rows_cfg;
   logic [CSR_DATA_W-1:0] cols_cfg;
   step_result_type       expected_steps[$];

   int             mismatch_count  = 0;
   int             results_checked = 0;
   int             items_sent      = 0;
   int             traces_sent     = 0;
   int             size_settings   = 0;
   bit             sender_gaps     = 1'b1;
   int             burst_left      = 0;
   int             hold_left       = 0;
   stall_mode_type stall_mode      = STALL_NONE;

   binary_image_dfs_direction_trace u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_direction     (rsp_direction),
      .rsp_has_direction (rsp_has_direction),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int rows_in_use();
      return (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
   endfunction

   function automatic int cols_in_use();
      return (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
   endfunction

   function automatic bit pixel_in_use(int r, int c);
      return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
   endfunction

   function automatic int pixel_index(int r, int c);
      return r * GRID_COLS + c;
   endfunction

   function automatic void walk_directions(int r0, int c0);
      int              fr[STACK_ENTRIES];
      int              fc[STACK_ENTRIES];
      int              fnext[STACK_ENTRIES];
      bit              fmoved[STACK_ENTRIES];
      step_result_type steps[$];
      int              depth;
      int              top;
      int              d;
      int              nr;
      int              nc;
      int              last_dir;
      bit              any_recorded;
      depth        = 0;
      last_dir     = 0;
      any_recorded = 1'b0;
      if (pixel_in_use(r0, c0)) begin
         visited_model[pixel_index(r0, c0)] = 1'b1;
         fr[0]     = r0;
         fc[0]     = c0;
         fnext[0]  = 0;
         fmoved[0] = 1'b0;
         depth     = 1;
      end
      while (depth > 0) begin
         top = depth - 1;
         if (fnext[top] >= DIR_COUNT) begin
            depth--;
         end else begin
            d = fnext[top];
            fnext[top]++;
            nr = fr[top] + ((d == DIR_DOWN) ? 1 : (d == DIR_UP) ? -1 : 0);
            nc = fc[top] + ((d == DIR_RIGHT) ? 1 : (d == DIR_LEFT) ? -1 : 0);
            if (pixel_in_use(nr, nc) && depth < STACK_ENTRIES) begin
               if (pixel_model[pixel_index(nr, nc)] && !visited_model[pixel_index(nr, nc)]) begin
                  if (fmoved[top] || !any_recorded || last_dir != d) begin
                     steps.push_back(step_result_type'{dir_type'(d), 1'b1, 1'b0});
                     last_dir     = d;
                     any_recorded = 1'b1;
                  end
                  fmoved[top] = 1'b1;
                  visited_model[pixel_index(nr, nc)] = 1'b1;
                  fr[depth]     = nr;
                  fc[depth]     = nc;
                  fnext[depth]  = 0;
                  fmoved[depth] = 1'b0;
                  depth++;
               end
            end
         end
      end
      if (steps.size() == 0) begin
         steps.push_back(step_result_type'{DIR_UP, 1'b0, 1'b1});
      end else begin
         steps[steps.size() - 1].last = 1'b1;
      end
      foreach (steps[k]) expected_steps.push_back(steps[k]);
   endfunction

   function automatic void apply_request(logic [OP_W-1:0] op, int r, int c, logic pix);
      case (op)
         OP_WRITE: begin
            if (pixel_in_use(r, c)) pixel_model[pixel_index(r, c)] = pix;
         end
         OP_INVERT: begin
            if (pixel_in_use(r, c)) pixel_model[pixel_index(r, c)] ^= 1'b1;
         end
         OP_CLEAR_GRID:    pixel_model = '0;
         OP_CLEAR_VISITED: visited_model = '0;
         OP_TRACE: begin
            walk_directions(r, c);
            traces_sent++;
         end
         default: ;
      endcase
      if (op != OP_TRACE) expected_steps.push_back(step_result_type'{DIR_UP, 1'b0, 1'b1});
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(GRID_ROWS + 1, 15));
         2, 3:    return CSR_DATA_W'(GRID_ROWS);
         default: return CSR_DATA_W'($urandom_range(1, GRID_ROWS));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic pix);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      if (burst_left > 0) burst_left--;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_row         <= r;
      req_col         <= c;
      req_pixel_value <= pix;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_request(op, r, c, pix);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (which == REG_IMAGE_ROWS) rows_cfg = value;
      else cols_cfg = value;
      @(posedge clock);
   endtask

   task automatic set_image_size(input logic [CSR_DATA_W-1:0] n_rows,
                                 input logic [CSR_DATA_W-1:0] n_cols);
      wait_for_results();
      write_reg(REG_IMAGE_ROWS, n_rows);
      write_reg(REG_IMAGE_COLS, n_cols);
      size_settings++;
   endtask

   task automatic test_basic_ops();
      send_item(OP_TRACE, 0, 0, 0);
      send_item(OP_CLEAR_VISITED, 7, 7, 1);
      send_item(OP_WRITE, 0, 1, 1);
      send_item(OP_WRITE, 0, 2, 1);
      send_item(OP_INVERT, 1, 2, 0);
      send_item(OP_WRITE, 7, 7, 1);
      send_item(OP_INVERT, 7, 6, 1);
      send_item(OP_WRITE, 7, 5, 1);
      send_item(OP_WRITE, 7, 5, 0);
      send_item(OP_TRACE, 0, 0, 1);
      send_item(OP_TRACE, 0, 0, 0);
      send_item(OP_CLEAR_VISITED, 0, 0, 0);
      send_item(OP_TRACE, 7, 7, 0);
      for (int k = OP_FIRST_UNUSED; k <= OP_LAST_CODE; k++) send_item(OP_W'(k), 5, 2, 1);
      send_item(OP_CLEAR_GRID, 3, 4, 0);
      send_item(OP_TRACE, 0, 1, 0);
      wait_for_results();
   endtask

   task automatic test_size_registers();
      logic [CSR_DATA_W-1:0] row_sizes[9] = '{0, 8, 1, 15, 3, 8, 1, 9, 8};
      logic [CSR_DATA_W-1:0] col_sizes[9] = '{8, 0, 1, 15, 5, 1, 8, 2, 8};
      send_item(OP_WRITE, 6, 6, 1);
      send_item(OP_WRITE, 6, 7, 1);
      set_image_size(3, 3);
      send_item(OP_CLEAR_VISITED, 0, 0, 0);
      send_item(OP_WRITE, 6, 6, 0);
      send_item(OP_INVERT, 6, 7, 0);
      send_item(OP_TRACE, 6, 6, 0);
      set_image_size(8, 8);
      send_item(OP_TRACE, 6, 6, 0);
      foreach (row_sizes[k]) begin
         set_image_size(row_sizes[k], col_sizes[k]);
         send_item(OP_CLEAR_VISITED, 0, 0, 0);
         repeat (6) begin
            send_item(($urandom_range(0, 1) != 0) ? OP_INVERT : OP_WRITE,
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
         end
         repeat (2) send_item(OP_TRACE, $urandom_range(0, 7), $urandom_range(0, 7), 1);
      end
      wait_for_results();
   endtask

   task automatic test_full_grid_hold();
      set_image_size(8, 8);
      stall_mode  = STALL_NONE;
      sender_gaps = 1'b0;
      send_item(OP_CLEAR_GRID, 0, 0, 0);
      send_item(OP_CLEAR_VISITED, 0, 0, 0);
      hold_left = HOLD_OFF_CYCLES;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) send_item(OP_WRITE, r, c, 1);
      end
      stall_mode  = STALL_RANDOM;
      sender_gaps = 1'b1;
      send_item(OP_TRACE, $urandom_range(0, 7), $urandom_range(0, 7), 0);
      wait_for_results();
      send_item(OP_CLEAR_VISITED, 0, 0, 0);
      repeat (14) send_item(OP_INVERT, $urandom_range(0, 7), $urandom_range(0, 7), 0);
      send_item(OP_TRACE, 0, 0, 0);
      wait_for_results();
   endtask

   task automatic test_random_shapes();
      int                 count;
      int                 len;
      int                 d;
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] r0;
      logic [COORD_W-1:0] c0;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         stall_mode  = stall_mode_type'($urandom_range(0, 3));
         sender_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) set_image_size(pick_size(), pick_size());
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 4) != 0) begin
               send_item(OP_CLEAR_VISITED, $urandom_range(0, 7), $urandom_range(0, 7), 0);
               count++;
            end
            if ($urandom_range(0, 3) == 0) begin
               send_item(OP_CLEAR_GRID, $urandom_range(0, 7), $urandom_range(0, 7), 1);
               count++;
            end
            r0  = $urandom_range(0, 7);
            c0  = $urandom_range(0, 7);
            r   = r0;
            c   = c0;
            len = $urandom_range(2, 14);
            repeat (len) begin
               send_item(($urandom_range(0, 4) == 0) ? OP_INVERT : OP_WRITE, r, c,
                         $urandom_range(0, 5) != 0);
               count++;
               d = $urandom_range(0, DIR_COUNT - 1);
               if (d == DIR_UP) r = r - 1;
               else if (d == DIR_DOWN) r = r + 1;
               else if (d == DIR_RIGHT) c = c + 1;
               else c = c - 1;
            end
            if ($urandom_range(0, 5) == 0) begin
               r0 = $urandom_range(0, 7);
               c0 = $urandom_range(0, 7);
            end
            send_item(OP_TRACE, r0, c0, $urandom_range(0, 1));
            count++;
         end else begin
            send_item(OP_W'($urandom_range(0, 7)), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 1));
            count++;
         end
      end
      wait_for_results();
   endtask

   // receiver back-pressure
   initial begin
      int phase;
      phase = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            case (stall_mode)
               STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
               STALL_PATTERN: rsp_stall <= ((phase % 7) < 3);
               STALL_HEAVY:   rsp_stall <= ($urandom_range(0, 99) < 75);
               default:       rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (expected_steps.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, rsp_direction);
         end else begin
            want = expected_steps.pop_front();
            if (rsp_direction !== want.direction)
               report_mismatch("direction", want.direction, rsp_direction);
            if (rsp_has_direction !== want.has_direction)
               report_mismatch("has_direction", want.has_direction, rsp_has_direction);
            if (rsp_last !== want.last)
               report_mismatch("last", want.last, rsp_last);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int waited;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_WRITE;
      req_row         <= '0;
      req_col         <= '0;
      req_pixel_value <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= REG_IMAGE_ROWS;
      csr_wdata       <= '0;
      pixel_model   = '0;
      visited_model = '0;
      rows_cfg      = CSR_DATA_W'(GRID_ROWS);
      cols_cfg      = CSR_DATA_W'(GRID_COLS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      stall_mode = STALL_PATTERN;
      test_size_registers();
      test_full_grid_hold();
      test_random_shapes();

      req_valid <= 1'b0;
      waited = 0;
      while (expected_steps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_steps.size() != 0)
         report_mismatch("responses never delivered", expected_steps.size(), 0);
      $display("Sent %0d requests including %0d traces; checked %0d responses.",
               items_sent, traces_sent, results_checked);
      $display("Used %0d image size settings, a full-grid walk and a %0d-cycle output hold-off.",
               size_settings, HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
